// ===== rtl/xtea_pkg.sv =====
`default_nettype none

package xtea_pkg;

    localparam logic [31:0] XTEA_DELTA = 32'h9E37_79B9;
    localparam int KEY_WORDS = 4;

    typedef logic [31:0] t_word;
    typedef logic [1:0]  t_key_index;

    typedef enum logic {
        MODE_ENCIPHER = 1'b0,
        MODE_DECIPHER = 1'b1
    } t_mode;

    function automatic t_word mix_half(input t_word v);
        return ((v << 4) ^ (v >> 5)) + v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/xtea_block_cipher_core.sv =====
`default_nettype none

// Throughput: one block per clock while the skid register is empty; each half update
// of a cycle has its own register stage.
// A one-entry output skid register lets one more block enter while a result waits.
// Reset (synchronous, active low) clears all stage valid bits, the skid valid bit and
// the four key words to zero; blocks in flight are discarded.
module xtea_block_cipher_core #(
    parameter int CYCLE_COUNT = 32
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_cfg_we,
    input  wire xtea_pkg::t_key_index  i_cfg_index,
    input  wire [31:0]                 i_cfg_data,
    input  wire                        i_s_tvalid,
    output logic                       o_s_tready,
    // Fields from bit 0: in_first_half[31:0], in_second_half[63:32].
    input  wire [63:0]                 i_s_tdata,
    // Fields from bit 0: mode[0].
    input  wire                        i_s_tuser,
    output logic                       o_m_tvalid,
    input  wire                        i_m_tready,
    // Fields from bit 0: out_first_half[31:0], out_second_half[63:32].
    output logic [63:0]                o_m_tdata
);
    import xtea_pkg::*;

    localparam int STAGES = 2 * CYCLE_COUNT;

    t_word r_key [KEY_WORDS];

    logic  c_valid [STAGES+1];
    logic  c_mode  [STAGES+1];
    t_word c_y     [STAGES+1];
    t_word c_z     [STAGES+1];

    logic  r_valid [STAGES];
    logic  r_mode  [STAGES];
    t_word r_y     [STAGES];
    t_word r_z     [STAGES];

    logic  r_skid_valid;
    t_word r_skid_y;
    t_word r_skid_z;

    logic  en;

    assign en         = !r_skid_valid;
    assign o_s_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < KEY_WORDS; k++) begin
                r_key[k] <= '0;
            end
        end else if (i_cfg_we) begin
            r_key[i_cfg_index] <= i_cfg_data;
        end
    end

    assign c_valid[0] = i_s_tvalid;
    assign c_mode[0]  = i_s_tuser;
    assign c_y[0]     = i_s_tdata[31:0];
    assign c_z[0]     = i_s_tdata[63:32];

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        localparam int ROUND = s / 2;
        localparam bit FIRST = (s % 2) == 0;
        localparam int ENC_N = FIRST ? ROUND : ROUND + 1;
        localparam int DEC_N = FIRST ? CYCLE_COUNT - ROUND : CYCLE_COUNT - ROUND - 1;
        localparam logic [63:0] ENC_P = 64'(XTEA_DELTA) * 64'(ENC_N);
        localparam logic [63:0] DEC_P = 64'(XTEA_DELTA) * 64'(DEC_N);
        localparam t_word ENC_SUM = ENC_P[31:0];
        localparam t_word DEC_SUM = DEC_P[31:0];
        localparam t_key_index ENC_KI = FIRST ? ENC_SUM[1:0] : ENC_SUM[12:11];
        localparam t_key_index DEC_KI = FIRST ? DEC_SUM[12:11] : DEC_SUM[1:0];

        logic  upd_y;
        t_word src;
        t_word dst;
        t_word key_sum;
        t_word f;
        t_word res;

        always_comb begin
            upd_y   = FIRST ? (c_mode[s] == MODE_ENCIPHER) : (c_mode[s] == MODE_DECIPHER);
            src     = upd_y ? c_z[s] : c_y[s];
            dst     = upd_y ? c_y[s] : c_z[s];
            key_sum = (c_mode[s] == MODE_DECIPHER) ? (DEC_SUM + r_key[DEC_KI])
                                                   : (ENC_SUM + r_key[ENC_KI]);
            f       = mix_half(src) ^ key_sum;
            res     = (c_mode[s] == MODE_DECIPHER) ? (dst - f) : (dst + f);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (en) begin
                r_valid[s] <= c_valid[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_mode[s] <= c_mode[s];
                r_y[s]    <= upd_y ? res : c_y[s];
                r_z[s]    <= upd_y ? c_z[s] : res;
            end
        end

        assign c_valid[s+1] = r_valid[s];
        assign c_mode[s+1]  = r_mode[s];
        assign c_y[s+1]     = r_y[s];
        assign c_z[s+1]     = r_z[s];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_m_tready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (r_valid[STAGES-1] && !i_m_tready) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_valid) begin
            r_skid_y <= r_y[STAGES-1];
            r_skid_z <= r_z[STAGES-1];
        end
    end

    assign o_m_tvalid = r_skid_valid || r_valid[STAGES-1];
    assign o_m_tdata  = r_skid_valid ? {r_skid_z, r_skid_y}
                                     : {r_z[STAGES-1], r_y[STAGES-1]};

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_valid[STAGES-1] && !i_m_tready))
        else $error("skid register filled without a stalled result");

    a_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |=> $stable(r_valid[STAGES-1]) && $stable(r_y[STAGES-1])
                         && $stable(r_z[STAGES-1]))
        else $error("last stage moved while the skid register was full");

    a_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> r_valid[0])
        else $error("accepted transfer did not enter the first stage");

endmodule

`default_nettype wire

// ===== bench/xtea_block_cipher_core_test.sv =====
`default_nettype none

module xtea_block_cipher_core_test;

    import xtea_pkg::*;

    localparam int XTEA_ROUNDS = 32;
    localparam int CYCLE_LIMIT = 500000;
    localparam int LONG_HOLD_CYCLES = 400;

    class xtea_block_tracker;
        t_word       key [4];
        logic [63:0] pending_blocks [$];
        int          errors;

        function new();
            int i;
            for (i = 0; i < 4; i++) key[i] = '0;
            errors = 0;
        endfunction

        function void set_key(int idx, t_word value);
            key[idx] = value;
        endfunction

        function t_word feistel_term(t_word v, t_word s, t_word k);
            t_word shuffled;
            shuffled = (v << 4) ^ (v >> 5);
            return (shuffled + v) ^ (s + k);
        endfunction

        function logic [63:0] encipher(t_word y, t_word z);
            t_word s;
            int    n;
            s = '0;
            for (n = 0; n < XTEA_ROUNDS; n++) begin
                y = y + feistel_term(z, s, key[s[1:0]]);
                s = s + XTEA_DELTA;
                z = z + feistel_term(y, s, key[s[12:11]]);
            end
            return {z, y};
        endfunction

        function logic [63:0] decipher(t_word y, t_word z);
            t_word s;
            int    n;
            s = XTEA_DELTA * XTEA_ROUNDS;
            for (n = 0; n < XTEA_ROUNDS; n++) begin
                z = z - feistel_term(y, s, key[s[12:11]]);
                s = s - XTEA_DELTA;
                y = y - feistel_term(z, s, key[s[1:0]]);
            end
            return {z, y};
        endfunction

        function logic [63:0] note_block(t_mode mode, t_word y, t_word z);
            logic [63:0] result;
            result = (mode == MODE_DECIPHER) ? decipher(y, z) : encipher(y, z);
            pending_blocks.push_back(result);
            return result;
        endfunction

        function void check_result(logic [63:0] got);
            logic [63:0] want;
            if (pending_blocks.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                want = pending_blocks.pop_front();
                if (got[31:0] !== want[31:0]) begin
                    $display("%0t: first half expected %h actual %h",
                             $time, want[31:0], got[31:0]);
                    errors++;
                end
                if (got[63:32] !== want[63:32]) begin
                    $display("%0t: second half expected %h actual %h",
                             $time, want[63:32], got[63:32]);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return pending_blocks.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    t_key_index  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    // Fields from bit 0: in_first_half[31:0], in_second_half[63:32].
    logic [63:0] i_s_tdata = '0;
    // Fields from bit 0: mode[0].
    logic        i_s_tuser = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    // Fields from bit 0: out_first_half[31:0], out_second_half[63:32].
    logic [63:0] o_m_tdata;

    bit calm = 1'b0;
    bit long_hold_req = 1'b0;
    int cycle_count = 0;

    xtea_block_tracker tracker = new();

    xtea_block_cipher_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Result side: checks each transfer and stalls in random bursts, or for one long stretch
    // on request so that the pipeline fills and holds off the input.
    initial begin : result_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (o_m_tvalid && i_m_tready) tracker.check_result(o_m_tdata);
            if (long_hold_req) begin
                hold_left = LONG_HOLD_CYCLES;
                long_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 15) == 0) begin
                stall_left = $urandom_range(1, 19) - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    task automatic send_block(input t_mode mode, input t_word y, input t_word z,
                              output logic [63:0] predicted);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {z, y};
        i_s_tuser  <= mode;
        do @(posedge i_clk); while (!o_s_tready);
        predicted = tracker.note_block(mode, y, z);
    endtask

    task automatic pause_sender();
        i_s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge i_clk);
    endtask

    task automatic drain_blocks();
        i_s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_key(input t_word k0, input t_word k1, input t_word k2,
                            input t_word k3);
        t_word words [4];
        int    i;
        words = '{k0, k1, k2, k3};
        for (i = 0; i < 4; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= t_key_index'(i);
            i_cfg_data  <= words[i];
            @(posedge i_clk);
            tracker.set_key(i, words[i]);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_word pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return t_word'(1) << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // Random blocks; a quarter of them run the previous result back through the opposite
    // direction, which should recover the earlier block.
    task automatic run_blocks(input int count, input bit gaps);
        logic [63:0] previous;
        logic [63:0] result;
        t_mode       previous_mode;
        t_mode       mode;
        bit          have_previous;
        have_previous = 1'b0;
        previous_mode = MODE_ENCIPHER;
        previous = '0;
        repeat (count) begin
            if (gaps && !calm && $urandom_range(0, 7) == 0) pause_sender();
            if (have_previous && $urandom_range(0, 3) == 0) begin
                mode = (previous_mode == MODE_ENCIPHER) ? MODE_DECIPHER : MODE_ENCIPHER;
                send_block(mode, previous[31:0], previous[63:32], result);
            end else begin
                mode = t_mode'($urandom_range(0, 1));
                send_block(mode, pick_word(), pick_word(), result);
            end
            previous = result;
            previous_mode = mode;
            have_previous = 1'b1;
        end
    endtask

    initial begin : stimulus
        logic [63:0] result;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_block(MODE_ENCIPHER, 32'h0000_0000, 32'h0000_0000, result);
        send_block(MODE_DECIPHER, result[31:0], result[63:32], result);
        send_block(MODE_ENCIPHER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, result);
        send_block(MODE_DECIPHER, 32'h0000_0000, 32'h0000_0000, result);
        send_block(MODE_DECIPHER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, result);
        send_block(MODE_ENCIPHER, 32'h8000_0000, 32'h0000_0001, result);
        send_block(MODE_ENCIPHER, 32'hAAAA_AAAA, 32'h5555_5555, result);
        send_block(MODE_DECIPHER, 32'h5555_5555, 32'hAAAA_AAAA, result);
        drain_blocks();

        load_key(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_block(MODE_ENCIPHER, 32'h0000_0000, 32'h0000_0000, result);
        send_block(MODE_DECIPHER, result[31:0], result[63:32], result);
        send_block(MODE_ENCIPHER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, result);
        send_block(MODE_DECIPHER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, result);
        send_block(MODE_ENCIPHER, 32'h4142_4344, 32'h4546_4748, result);
        send_block(MODE_DECIPHER, 32'h0000_0001, 32'h8000_0000, result);
        run_blocks(300, 1'b1);
        drain_blocks();

        load_key(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        run_blocks(300, 1'b1);
        drain_blocks();

        load_key($urandom, $urandom, $urandom, $urandom);
        long_hold_req = 1'b1;
        run_blocks(200, 1'b0);
        drain_blocks();

        load_key(32'h0001_0203, 32'h0405_0607, 32'h0809_0A0B, 32'h0C0D_0E0F);
        run_blocks(300, 1'b1);
        drain_blocks();

        load_key($urandom, $urandom, $urandom, $urandom);
        calm = 1'b1;
        run_blocks(300, 1'b1);
        i_s_tvalid <= 1'b0;

        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (2 * XTEA_ROUNDS + 8) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire
